// ===== src/u2u8_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_pkg: shared types and constants for the UTF-16 to UTF-8 encoder
// Holds the command word passed from the front end to the byte serializer
// and the sizes of that word and of the command queue.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    localparam int UNIT_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int MAX_BYTES  = 4;
    localparam int IDX_W      = $clog2(MAX_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    // One encoded code point: up to four bytes, first byte in slot 0,
    // last_idx is the slot of the final byte (byte count minus one).
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [IDX_W-1:0]                 last_idx;
    } t_cmd;

endpackage

// ===== src/u2u8_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_front: code unit classifier and UTF-8 byte builder
// Accepts one UTF-16 code unit per cycle unless the queue is full, pairs
// surrogates, and queues the UTF-8 bytes of each completed code point.
// ----------------------------------------------------------------------------
module u2u8_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [u2u8_pkg::UNIT_W-1:0]   i_code_unit,
    input  logic                          i_q_full,
    output logic                          o_push,
    output u2u8_pkg::t_cmd                o_cmd
);

    logic        r_pend_valid;
    logic [9:0]  r_pend_bits;
    logic        n_pend_valid;
    logic [9:0]  n_pend_bits;

    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        pair;
    logic [20:0] cp;

    // classification
    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign is_high = (i_code_unit[15:10] == 6'b110110);
    assign is_low  = (i_code_unit[15:10] == 6'b110111);
    assign pair    = r_pend_valid && is_low;

    // code point: surrogate pair or the unit itself
    always_comb begin
        if (pair) begin
            cp = {1'b0, r_pend_bits, i_code_unit[9:0]} + 21'h10000;
        end else begin
            cp = {5'b0, i_code_unit};
        end
    end

    // push unless the unit is a high surrogate or an unpaired low one
    assign o_push = accept && !is_high && (!is_low || pair);

    // UTF-8 byte build
    always_comb begin
        o_cmd = '0;
        if (cp < 21'h80) begin
            o_cmd.bytes[0] = cp[7:0];
            o_cmd.last_idx = 2'd0;
        end else if (cp < 21'h800) begin
            o_cmd.bytes[0] = 8'hC0 | {3'b0, cp[10:6]};
            o_cmd.bytes[1] = 8'h80 | {2'b0, cp[5:0]};
            o_cmd.last_idx = 2'd1;
        end else if (cp < 21'h10000) begin
            o_cmd.bytes[0] = 8'hE0 | {4'b0, cp[15:12]};
            o_cmd.bytes[1] = 8'h80 | {2'b0, cp[11:6]};
            o_cmd.bytes[2] = 8'h80 | {2'b0, cp[5:0]};
            o_cmd.last_idx = 2'd2;
        end else begin
            o_cmd.bytes[0] = 8'hF0 | {5'b0, cp[20:18]};
            o_cmd.bytes[1] = 8'h80 | {2'b0, cp[17:12]};
            o_cmd.bytes[2] = 8'h80 | {2'b0, cp[11:6]};
            o_cmd.bytes[3] = 8'h80 | {2'b0, cp[5:0]};
            o_cmd.last_idx = 2'd3;
        end
    end

    // held high surrogate: any accepted unit other than a high one clears it
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_pend_bits  = r_pend_bits;
        if (accept) begin
            n_pend_valid = is_high;
            n_pend_bits  = is_high ? i_code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_pend_bits  <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_pend_bits  <= n_pend_bits;
        end
    end

endmodule

// ===== src/u2u8_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_queue: short command queue
// Two-entry FIFO between the front end and the serializer so that each
// side stalls on its own.
// ----------------------------------------------------------------------------
module u2u8_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u2u8_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output u2u8_pkg::t_cmd  o_head
);

    u2u8_pkg::t_cmd                    r_mem [u2u8_pkg::QUEUE_DEPTH];
    logic [u2u8_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [u2u8_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [u2u8_pkg::QCNT_W-1:0]       r_count;
    logic [u2u8_pkg::QCNT_W-1:0]       n_count;

    assign o_full  = (r_count == u2u8_pkg::QCNT_W'(u2u8_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== src/u2u8_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_back: byte serializer
// Walks the queue's head command into the output register one byte per
// cycle unless stalled; flags the final byte, pops the command after it.
// ----------------------------------------------------------------------------
module u2u8_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  u2u8_pkg::t_cmd                i_head,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u2u8_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_last_byte
);

    logic                         r_valid;
    logic [u2u8_pkg::BYTE_W-1:0]  r_byte;
    logic                         r_last;
    logic [u2u8_pkg::IDX_W-1:0]   r_idx;
    logic                         advance;
    logic                         load;
    logic                         is_last;

    // output register free or being emptied this cycle
    assign advance = !r_valid || i_ready;
    assign load    = advance && !i_q_empty;
    assign is_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && is_last;

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

    // byte index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (advance) begin
                r_valid <= !i_q_empty;
            end
            if (load) begin
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= is_last;
        end
    end

endmodule

// ===== src/utf16_to_utf8_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder: UTF-16 code units in, UTF-8 bytes out
// Takes one code unit per word and sends the UTF-8 bytes of each completed
// code point, one byte per output word, with o_last_byte on the final one.
// ----------------------------------------------------------------------------
// A unit yields one to three bytes for a BMP character, four for a
// surrogate pair (counted on the low surrogate), none for a held high
// surrogate or a dropped lone low surrogate. The output side moves one
// byte per cycle while the receiver is ready, and that serializer sets
// the sustained rate; a two-entry command queue lets new units be taken
// while earlier bytes are still going out, so up to two encoded code
// points plus the byte in the output register can be in flight. A zero
// unit gives one zero byte and drops any held high surrogate; a high
// surrogate not followed by a low one is dropped without output. A
// unit's bytes pass through a queue entry into the output register.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [u2u8_pkg::UNIT_W-1:0]   i_code_unit,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [u2u8_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                          o_last_byte
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    u2u8_pkg::t_cmd  q_in;
    u2u8_pkg::t_cmd  q_head;

    // classifier and byte builder
    u2u8_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_code_unit (i_code_unit),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (q_in)
    );

    // command queue
    u2u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // byte serializer
    u2u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

endmodule

// ===== src/u2u8_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_checker: port-level checks for the encoder
// Watches both streams for a held word and the output for well-formed UTF-8
// sequences: lead byte first, continuation bytes after, at most four.
// ----------------------------------------------------------------------------
module u2u8_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic [u2u8_pkg::UNIT_W-1:0]   i_code_unit,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic [u2u8_pkg::BYTE_W-1:0]   o_out_byte,
    input  logic                          o_last_byte
);

    logic                        out_take;
    logic [u2u8_pkg::IDX_W-1:0]  r_run;

    assign out_take = o_valid && i_ready;

    // bytes already sent in the current sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (out_take) begin
            r_run <= o_last_byte ? '0 : r_run + 1'b1;
        end
    end

    // stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_code_unit))
        else $error("input word changed while stalled");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_last_byte))
        else $error("output word changed while stalled");

    // sequence never runs past four bytes
    a_max_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && (r_run == 2'd3) |-> o_last_byte)
        else $error("UTF-8 sequence longer than four bytes");

    // first byte of a sequence is never a continuation byte
    a_lead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && (r_run == 2'd0) |-> (o_out_byte[7:6] != 2'b10))
        else $error("sequence starts with a continuation byte");

    // later bytes are continuation bytes
    a_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && (r_run != 2'd0) |-> (o_out_byte[7:6] == 2'b10))
        else $error("non-continuation byte inside a sequence");

endmodule

bind utf16_to_utf8_encoder u2u8_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_code_unit (i_code_unit),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_out_byte  (o_out_byte),
    .o_last_byte (o_last_byte)
);

// ===== tb/sv/utf16_to_utf8_encoder_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_test: self-checking bench for the UTF-16 to UTF-8 encoder
// Feeds code units through the input handshake and predicts each UTF-8 byte,
// with its last-byte flag, from a behavioral encoder kept in the bench. Every
// output word is checked in order. Covers single units of each length,
// surrogate pairs and their broken forms, random text, and a long output
// stall that backs the block up into its input.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_test;

    localparam int UNIT_W       = u2u8_pkg::UNIT_W;
    localparam int BYTE_W       = u2u8_pkg::BYTE_W;

    localparam int HALF_PERIOD  = 4;
    localparam int CYCLE_LIMIT  = 60000;
    localparam int IDLE_PCT     = 14;
    localparam int STALL_CYCLES = 80;
    localparam int RANDOM_UNITS = 185;
    localparam int CALM_FROM    = 90;
    localparam int CALM_TO      = 140;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [UNIT_W-1:0] HIGH_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] HIGH_LAST  = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LOW_FIRST  = 16'hDC00;
    localparam logic [UNIT_W-1:0] LOW_LAST   = 16'hDFFF;
    localparam logic [UNIT_W-1:0] UNIT_END   = 16'h0000;

    typedef enum int {TXT_ASCII, TXT_TWO, TXT_THREE, TXT_PAIR, TXT_NOISE} t_text_kind;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_utf8_byte;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [UNIT_W-1:0] i_code_unit = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_last_byte;

    // bench-side encoder state and the bytes still owed by the block
    t_utf8_byte expected_bytes[$];
    t_utf8_byte byte_due;
    logic       held_high = 1'b0;
    logic [9:0] held_bits = '0;

    logic sender_calm = 1'b0;
    logic receiver_calm = 1'b0;
    int   stall_requests = 0;
    int   stall_served = 0;
    int   stall_left = 0;
    int   cycle_count = 0;
    int   errors = 0;

    utf16_to_utf8_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_code_unit (i_code_unit),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_last_byte (o_last_byte)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // UTF-8 bytes of one code point, lead byte first
    function automatic void push_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            expected_bytes.push_back('{data: cp[7:0], last: 1'b1});
        end else if (cp < 21'h800) begin
            expected_bytes.push_back('{data: {3'b110, cp[10:6]}, last: 1'b0});
            expected_bytes.push_back('{data: {2'b10, cp[5:0]}, last: 1'b1});
        end else if (cp < 21'h10000) begin
            expected_bytes.push_back('{data: {4'b1110, cp[15:12]}, last: 1'b0});
            expected_bytes.push_back('{data: {2'b10, cp[11:6]}, last: 1'b0});
            expected_bytes.push_back('{data: {2'b10, cp[5:0]}, last: 1'b1});
        end else begin
            expected_bytes.push_back('{data: {5'b11110, cp[20:18]}, last: 1'b0});
            expected_bytes.push_back('{data: {2'b10, cp[17:12]}, last: 1'b0});
            expected_bytes.push_back('{data: {2'b10, cp[11:6]}, last: 1'b0});
            expected_bytes.push_back('{data: {2'b10, cp[5:0]}, last: 1'b1});
        end
    endfunction

    // one accepted unit: update held surrogate, queue the bytes it completes
    function automatic void encode_unit(input logic [UNIT_W-1:0] unit);
        logic [20:0] cp;
        logic        is_high;
        logic        is_low;
        is_high = (unit >= HIGH_FIRST) && (unit <= HIGH_LAST);
        is_low  = (unit >= LOW_FIRST) && (unit <= LOW_LAST);
        if (unit == UNIT_END) begin
            held_high = 1'b0;
            held_bits = '0;
            expected_bytes.push_back('{data: '0, last: 1'b1});
        end else if (held_high && is_low) begin
            cp = {1'b0, held_bits, unit[9:0]} + 21'h10000;
            held_high = 1'b0;
            held_bits = '0;
            push_code_point(cp);
        end else begin
            // a held high surrogate not followed by a low one is lost
            held_high = 1'b0;
            held_bits = '0;
            if (is_high) begin
                held_high = 1'b1;
                held_bits = unit[9:0];
            end else if (!is_low) begin
                push_code_point({5'b0, unit});
            end
        end
    endfunction

    // random BMP character needing three bytes, never a surrogate
    function automatic logic [UNIT_W-1:0] random_three_byte();
        if ($urandom_range(0, 1) == 0)
            return UNIT_W'($urandom_range(16'h0800, 16'hD7FF));
        return UNIT_W'($urandom_range(16'hE000, 16'hFFFF));
    endfunction

    // offer one word and wait until the block takes it
    task automatic send_unit(input logic [UNIT_W-1:0] unit);
        int gap;
        @(negedge i_clk);
        if (!sender_calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_code_unit <= unit;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        encode_unit(unit);
    endtask

    // receiver: random ready, plus long hold-offs on request
    always @(negedge i_clk) begin
        if (stall_left == 0 && stall_requests != stall_served) begin
            stall_served++;
            stall_left = STALL_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= receiver_calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // output check and cycle limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes still owed", $time, expected_bytes.size());
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected word, expected none, actual byte %02h last %0b",
                         $time, o_out_byte, o_last_byte);
            end else begin
                byte_due = expected_bytes.pop_front();
                if (o_out_byte !== byte_due.data) begin
                    errors++;
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, byte_due.data, o_out_byte);
                end
                if (o_last_byte !== byte_due.last) begin
                    errors++;
                    $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                             $time, byte_due.last, o_last_byte);
                end
            end
        end
    end

    // one-, two- and three-byte boundaries and the end-of-text unit
    task automatic test_single_units();
        send_unit(16'h0041);
        send_unit(16'h007F);
        send_unit(UNIT_END);
        send_unit(16'h0001);
        send_unit(16'h0080);
        send_unit(16'h07FF);
        send_unit(16'h0800);
        send_unit(16'hD7FF);
        send_unit(16'hE000);
        send_unit(16'hFFFF);
    endtask

    // pairs at both ends, broken pairs, lone low, zero clearing a held high
    task automatic test_surrogate_pairs();
        send_unit(HIGH_FIRST);
        send_unit(LOW_FIRST);
        send_unit(HIGH_LAST);
        send_unit(LOW_LAST);
        send_unit(16'hD83D);
        send_unit(16'hDE00);
        send_unit(HIGH_FIRST);
        send_unit(16'h0041);
        send_unit(HIGH_FIRST);
        send_unit(HIGH_LAST);
        send_unit(LOW_FIRST);
        send_unit(LOW_LAST);
        send_unit(HIGH_FIRST);
        send_unit(UNIT_END);
        send_unit(LOW_FIRST);
    endtask

    // mostly well-formed text with random content, some noise
    task automatic test_random_text();
        int         sent;
        int         pick;
        t_text_kind kind;
        sent = 0;
        while (sent < RANDOM_UNITS) begin
            sender_calm   = (sent >= CALM_FROM) && (sent < CALM_TO);
            receiver_calm = sender_calm;
            pick = $urandom_range(0, 99);
            if (pick < 35)      kind = TXT_ASCII;
            else if (pick < 50) kind = TXT_TWO;
            else if (pick < 70) kind = TXT_THREE;
            else if (pick < 88) kind = TXT_PAIR;
            else                kind = TXT_NOISE;
            case (kind)
                TXT_ASCII: begin
                    send_unit(UNIT_W'($urandom_range(1, 16'h7F)));
                    sent++;
                end
                TXT_TWO: begin
                    send_unit(UNIT_W'($urandom_range(16'h80, 16'h7FF)));
                    sent++;
                end
                TXT_THREE: begin
                    send_unit(random_three_byte());
                    sent++;
                end
                TXT_PAIR: begin
                    send_unit(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
                    send_unit(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)));
                    sent += 2;
                end
                default: begin
                    case ($urandom_range(0, 4))
                        0: send_unit(UNIT_W'($urandom_range(0, 16'hFFFF)));
                        1: send_unit(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)));
                        2: begin
                            send_unit(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
                            send_unit(random_three_byte());
                            sent++;
                        end
                        3: begin
                            send_unit(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
                            send_unit(UNIT_END);
                            sent++;
                        end
                        default: send_unit(UNIT_END);
                    endcase
                    sent++;
                end
            endcase
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering wide characters
    task automatic test_output_stall();
        int n;
        stall_requests++;
        sender_calm = 1'b1;
        for (n = 0; n < 16; n++) begin
            if (n % 4 == 3) begin
                send_unit(UNIT_W'($urandom_range(HIGH_FIRST, HIGH_LAST)));
                send_unit(UNIT_W'($urandom_range(LOW_FIRST, LOW_LAST)));
            end else begin
                send_unit(random_three_byte());
            end
        end
        sender_calm = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_units();
        test_surrogate_pairs();
        test_output_stall();
        test_random_text();

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
